// File: rtl/lpmr_pkg.sv
// shared types, constants and status codes of the longest prefix match router
`timescale 1ns / 1ps

package lpmr_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int ADDR_W            = 32;
    localparam int LEN_W             = 6;
    localparam int IFACE_W           = 4;
    localparam int TTL_W             = 8;
    localparam int STATUS_W          = 2;

    localparam logic [LEN_W-1:0]    MAX_LEN = LEN_W'(ADDR_W);

    localparam logic                MODE_ADD   = 1'b0;
    localparam logic                MODE_ROUTE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TTL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOROUTE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic               mode;
        logic [ADDR_W-1:0]  address;
        logic [LEN_W-1:0]   prefix_len;
        logic               next_hop_valid;
        logic [ADDR_W-1:0]  next_hop_address;
        logic [IFACE_W-1:0] interface_index;
        logic [TTL_W-1:0]   ttl;
    } in_beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TTL_W-1:0]    ttl_out;
        logic [IFACE_W-1:0]  out_interface;
        logic [ADDR_W-1:0]   next_hop_out;
    } out_beat_t;

    // one stored route
    typedef struct packed {
        logic [ADDR_W-1:0]  prefix;
        logic [LEN_W-1:0]   len;
        logic               hop_valid;
        logic [ADDR_W-1:0]  hop_addr;
        logic [IFACE_W-1:0] iface;
    } route_t;

    // search token passed from cell to cell
    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  dst;
        logic [TTL_W-1:0]   ttl;
        logic               found;
        logic [LEN_W-1:0]   best_len;
        logic [IFACE_W-1:0] iface;
        logic [ADDR_W-1:0]  hop;
    } token_t;

endpackage

// File: rtl/longest_prefix_match_router.sv
// top level of the longest prefix match router: control, cell chain and result register
`timescale 1ns / 1ps

// ipv4 forwarding table built as a row of TABLE_ENTRIES cells, each holding
// one route. an add beat writes the next free cell and its result is
// ready on the following cycle; an add into a full table stores nothing
// and reports table full. a route beat with ttl 0 or 1 is answered at once
// as expired. any other route beat becomes a search token that walks the
// cell chain one cell per clock; the result is registered once the token
// leaves the last cell. the longest matching prefix wins and a later route
// beats an earlier one of equal length, which falls out of the token
// visiting the cells in insertion order. one beat is in the block at
// a time: in_ready is high when no search is running and the result
// register is empty or being drained in the same cycle.

module longest_prefix_match_router
    import lpmr_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_BUSY = 1'b1;

    logic             state_reg;
    logic             state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    out_beat_t        out_reg;
    out_beat_t        out_next;

    logic             in_fire;
    logic             is_add;
    logic             table_full;
    logic             do_write;
    logic             ttl_expired;
    logic             start_search;
    route_t           wr_route;
    token_t           chain [0:TABLE_ENTRIES];

    assign in_ready     = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire      = in_valid && in_ready;
    assign is_add       = (in_data.mode == MODE_ADD);
    assign table_full   = (count_reg == CNT_W'(TABLE_ENTRIES));
    assign do_write     = in_fire && is_add && !table_full;
    assign ttl_expired  = (in_data.ttl <= TTL_W'(1));
    assign start_search = in_fire && !is_add && !ttl_expired;

    // route being written, length saturated at 32
    always_comb
    begin
        wr_route.prefix    = in_data.address;
        wr_route.len       = (in_data.prefix_len > MAX_LEN) ? MAX_LEN : in_data.prefix_len;
        wr_route.hop_valid = in_data.next_hop_valid;
        wr_route.hop_addr  = in_data.next_hop_address;
        wr_route.iface     = in_data.interface_index;
    end

    // token entering the first cell, ttl already decremented
    always_comb
    begin
        chain[0].valid    = start_search;
        chain[0].dst      = in_data.address;
        chain[0].ttl      = in_data.ttl - TTL_W'(1);
        chain[0].found    = 1'b0;
        chain[0].best_len = '0;
        chain[0].iface    = '0;
        chain[0].hop      = '0;
    end

    // the cell chain, slot i holds the i-th route added
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        lpmr_cell #(
            .ENTRIES (TABLE_ENTRIES),
            .INDEX   (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wr_en    (do_write && (count_reg == CNT_W'(i))),
            .wr_route (wr_route),
            .count    (count_reg),
            .tok_in   (chain[i]),
            .tok_out  (chain[i+1])
        );
    end

    // control and result register
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;

        if (do_write)
        begin
            count_next = count_reg + CNT_W'(1);
        end

        priority if (in_fire && is_add)
        begin
            out_valid_next = 1'b1;
            out_next       = '0;
            out_next.status = table_full ? ST_FULL : ST_OK;
        end
        else if (in_fire && ttl_expired)
        begin
            out_valid_next  = 1'b1;
            out_next        = '0;
            out_next.status = ST_TTL;
        end
        else if (start_search)
        begin
            state_next = S_BUSY;
        end
        else if (chain[TABLE_ENTRIES].valid)
        begin
            // token has left the last cell
            state_next     = S_IDLE;
            out_valid_next = 1'b1;
            out_next       = '0;
            if (chain[TABLE_ENTRIES].found)
            begin
                out_next.status        = ST_OK;
                out_next.ttl_out       = chain[TABLE_ENTRIES].ttl;
                out_next.out_interface = chain[TABLE_ENTRIES].iface;
                out_next.next_hop_out  = chain[TABLE_ENTRIES].hop;
            end
            else
            begin
                out_next.status = ST_NOROUTE;
            end
        end
        else
        begin
            state_next = state_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // a token only reaches the end of the chain while a search is running
    a_token_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        chain[TABLE_ENTRIES].valid |-> (state_reg == S_BUSY))
        else $error("search token left the chain with no search running");

    // route count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("route count beyond table size");

    // add into a full table reports full and leaves the count alone
    a_full_add: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_add && table_full) |=>
            (out_valid && (out_data.status == ST_FULL) && $stable(count_reg)))
        else $error("add into full table not reported");

    // a search beat keeps the block busy and yields no result on the next edge
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start_search |=> ((state_reg == S_BUSY) && !out_valid))
        else $error("search did not occupy the chain");

endmodule

// File: rtl/lpmr_cell.sv
// one table cell: holds a route and updates the passing search token
`timescale 1ns / 1ps

module lpmr_cell
    import lpmr_pkg::*;
#(
    parameter int ENTRIES = TABLE_ENTRIES_DEF,
    parameter int INDEX   = 0
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  route_t                         wr_route,
    input  logic [$clog2(ENTRIES+1)-1:0]   count,
    input  token_t                         tok_in,
    output token_t                         tok_out
);

    localparam int CNT_W = $clog2(ENTRIES + 1);

    route_t             route_reg;
    token_t             tok_reg;
    token_t             tok_next;
    logic [ADDR_W-1:0]  mask;
    logic               active;
    logic               hit;

    // route store, no reset: only slots below count are ever looked at
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            route_reg <= wr_route;
        end
    end

    // leading-ones mask of the stored length
    always_comb
    begin
        for (int k = 0; k < ADDR_W; k++)
        begin
            mask[ADDR_W-1-k] = (LEN_W'(k) < route_reg.len);
        end
    end

    assign active = (count > CNT_W'(INDEX));
    assign hit    = active && (route_reg.len >= tok_in.best_len)
                    && (((tok_in.dst ^ route_reg.prefix) & mask) == '0);

    always_comb
    begin
        tok_next = tok_in;
        if (hit)
        begin
            tok_next.found    = 1'b1;
            tok_next.best_len = route_reg.len;
            tok_next.iface    = route_reg.iface;
            tok_next.hop      = route_reg.hop_valid ? route_reg.hop_addr : tok_in.dst;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule
